// ===== rtl/rcop_pkg.sv =====
package rcop_pkg;

   localparam int COS_TABLE_DEPTH = 256;
   localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
   // Phase index covers four quarter waves.
   localparam int FULL_W          = COS_IDX_W + 2;
   // The phase numerator is the remainder times twice the full-wave count.
   localparam int IDX_SHIFT       = COS_IDX_W + 3;

   localparam int POS_W  = 32;
   localparam int CNT_W  = 24;
   localparam int PER_W  = 16;
   localparam int CYC_W  = 8;
   localparam int COS_W  = 16;
   localparam int DVS_W  = PER_W + 1;
   localparam int DIV_W  = DVS_W + IDX_SHIFT;
   localparam int PROD_W = POS_W + COS_W + 3;
   localparam int SUM_W  = POS_W + 3;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TICKS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_COUNT  = 8'd2;

   localparam logic [PER_W-1:0] PERIOD_RESET = 16'd1000;
   localparam logic [CYC_W-1:0] CYCLES_RESET = 8'd2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [COS_W-1:0] cos_table_type [COS_TABLE_DEPTH];

   typedef struct packed {
      logic load_item;
      logic start_mod;
      logic start_idx;
      logic read_table;
      logic multiply;
      logic sum;
      logic write_out;
   } rcop_cmd_type;

   typedef struct packed {
      logic hit;
      logic div_done;
      logic out_free;
   } rcop_sts_type;

   // Quarter-wave sine in Q0.16, from a Q30 Taylor series up to x^17.
   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] r;
      logic signed [63:0] acc;
      for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
         x    = 64'(i) * HALF_PI_Q30 / COS_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         acc  = $signed(x);
         term = ((term * x2) >> 30) / 64'd6;   acc = acc - $signed(term);
         term = ((term * x2) >> 30) / 64'd20;  acc = acc + $signed(term);
         term = ((term * x2) >> 30) / 64'd42;  acc = acc - $signed(term);
         term = ((term * x2) >> 30) / 64'd72;  acc = acc + $signed(term);
         term = ((term * x2) >> 30) / 64'd110; acc = acc - $signed(term);
         term = ((term * x2) >> 30) / 64'd156; acc = acc + $signed(term);
         term = ((term * x2) >> 30) / 64'd210; acc = acc - $signed(term);
         term = ((term * x2) >> 30) / 64'd272; acc = acc + $signed(term);
         if (acc < 0) begin
            tbl[i] = '0;
         end else begin
            r = ($unsigned(acc) + 64'd8192) >> 14;
            tbl[i] = (r > 64'd65535) ? 16'hFFFF : r[COS_W-1:0];
         end
      end
      return tbl;
   endfunction

   localparam cos_table_type COS_TABLE = build_cos_table();

endpackage

// ===== rtl/rcop_div.sv =====
module rcop_div import rcop_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder,
   output logic             done
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;

   logic [DVS_W:0]    trial;
   logic              fits;
   logic [DVS_W:0]    diff;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         step_ff <= STEP_W'(DIV_W);
         done_ff <= 1'b0;
      end else if (step_ff != '0) begin
         step_ff <= step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (step_ff != '0) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ===== rtl/rcop_ctrl.sv =====
module rcop_ctrl import rcop_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rcop_sts_type sts,
   output rcop_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOD   = 3'd1;
   localparam logic [2:0] S_IDX   = 3'd2;
   localparam logic [2:0] S_LOOK  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_WRITE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (sts.hit) begin
                  cmd.start_mod = 1'b1;
                  state_in      = S_MOD;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_MOD: begin
            if (sts.div_done) begin
               cmd.start_idx = 1'b1;
               state_in      = S_IDX;
            end
         end
         S_IDX: begin
            if (sts.div_done) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.read_table = 1'b1;
            state_in       = S_MUL;
         end
         S_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (sts.out_free) begin
               cmd.write_out = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== rtl/rcop_dpath.sv =====
module rcop_dpath import rcop_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  rcop_cmd_type          cmd,
   output rcop_sts_type          sts,
   input  logic                  req_first_tick,
   input  logic signed [POS_W-1:0] req_actual_pos,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [POS_W-1:0] rsp_target_pos,
   output logic                  rsp_target_valid,
   output logic [CNT_W-1:0]      rsp_ticks_left,
   output logic                  rsp_move_done,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic signed [SUM_W-1:0] SUM_POS_MAX =
      {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_POS_MIN =
      {{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

   // Configuration registers.
   logic signed [POS_W-1:0] amp_ff;
   logic [PER_W-1:0]        period_ff;
   logic [CYC_W-1:0]        cycles_ff;

   // Move state.
   logic [CNT_W-1:0]        tick_ff;
   logic signed [POS_W-1:0] base_ff;

   // Per-item staging.
   logic                    hit_ff;
   logic                    outer_ff;
   logic                    add_ff;
   logic [CNT_W-1:0]        left_ff;
   logic                    done_ff;
   logic [COS_W+1:0]        c_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [POS_W-1:0] target_ff;

   // Result register.
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_target_ff;
   logic                    rsp_tvalid_ff;
   logic [CNT_W-1:0]        rsp_left_ff;
   logic                    rsp_done_ff;

   logic [CNT_W-1:0]        tick_in;
   logic [CNT_W-1:0]        half_w;
   logic [CNT_W-1:0]        total_w;
   logic [CNT_W-1:0]        tail_w;
   logic                    total_ge_half;
   logic                    seg1;
   logic                    seg2;
   logic                    seg3;
   logic                    latch_base;
   logic [CNT_W-1:0]        phase_j;

   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend;
   logic [DVS_W-1:0]        div_divisor;
   logic [DIV_W-1:0]        div_quotient;
   logic [DVS_W-1:0]        div_remainder;
   logic                    div_done;

   logic [FULL_W-1:0]       phase_idx;
   logic [1:0]              quad;
   logic [COS_IDX_W-1:0]    frac;
   logic [COS_IDX_W-1:0]    tbl_addr;
   logic [COS_W:0]          cos_mag;
   logic [COS_W+1:0]        c_in;

   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] swing_full;
   logic signed [SUM_W-1:0]  swing;
   logic signed [SUM_W-1:0]  base_ext;
   logic signed [SUM_W-1:0]  sum_w;
   logic signed [POS_W-1:0]  target_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff    <= '0;
         period_ff <= PERIOD_RESET;
         cycles_ff <= CYCLES_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AMPLITUDE:    amp_ff    <= $signed(csr_data[POS_W-1:0]);
            CSR_PERIOD_TICKS: period_ff <= csr_data[PER_W-1:0];
            CSR_CYCLE_COUNT:  cycles_ff <= csr_data[CYC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Segment decode for the tick being accepted.
   always_comb begin
      if (req_first_tick) begin
         tick_in = CNT_W'(1);
      end else if (tick_ff != CNT_MAX) begin
         tick_in = tick_ff + 1'b1;
      end else begin
         tick_in = tick_ff;
      end
   end

   assign half_w        = CNT_W'(period_ff >> 1);
   assign total_w       = CNT_W'(cycles_ff) * CNT_W'(period_ff);
   assign tail_w        = total_w - half_w;
   assign total_ge_half = total_w >= half_w;

   assign seg1 = (tick_in >= CNT_W'(1)) && (tick_in <= half_w);
   assign seg2 = !seg1 && (tick_in > half_w) && total_ge_half && (tick_in <= tail_w);
   assign seg3 = !seg1 && !seg2 && total_ge_half && (tick_in > tail_w)
                 && (tick_in <= total_w);

   always_comb begin
      latch_base = 1'b0;
      phase_j    = tick_in;
      if (seg1) begin
         latch_base = (tick_in == CNT_W'(1));
      end else if (seg2) begin
         latch_base = (tick_in == half_w + 1'b1);
         phase_j    = tick_in - half_w;
      end else if (seg3) begin
         latch_base = (tick_in == tail_w + 1'b1);
         phase_j    = tick_in - tail_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         base_ff <= '0;
      end else if (cmd.load_item) begin
         tick_ff <= tick_in;
         if (latch_base) begin
            base_ff <= req_actual_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         hit_ff   <= seg1 | seg2 | seg3;
         outer_ff <= !seg2;
         add_ff   <= seg1;
         left_ff  <= (tick_in < total_w) ? total_w - tick_in : '0;
         done_ff  <= tick_in >= total_w;
      end
   end

   // One divider serves both the tick-in-period remainder and the phase index.
   assign div_start    = cmd.start_mod | cmd.start_idx;
   assign div_dividend = cmd.start_mod
                         ? DIV_W'(phase_j)
                         : (DIV_W'(div_remainder[PER_W-1:0]) << IDX_SHIFT)
                           + DIV_W'(period_ff);
   assign div_divisor  = cmd.start_mod ? {1'b0, period_ff} : {period_ff, 1'b0};

   rcop_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // Quarter-wave lookup; cos is negative in the second and third quarters.
   assign phase_idx = div_quotient[FULL_W-1:0];
   assign quad      = phase_idx[FULL_W-1 -: 2];
   assign frac      = phase_idx[COS_IDX_W-1:0];
   assign tbl_addr  = quad[0] ? frac : COS_IDX_W'(COS_TABLE_DEPTH - 32'(frac));

   always_comb begin
      if (!quad[0] && (frac == '0)) begin
         cos_mag = (COS_W+1)'(1) << COS_W;
      end else begin
         cos_mag = {1'b0, COS_TABLE[tbl_addr]};
      end
      if (quad == 2'd1 || quad == 2'd2) begin
         c_in = ((COS_W+2)'(1) << COS_W) + (COS_W+2)'(cos_mag);
      end else begin
         c_in = ((COS_W+2)'(1) << COS_W) - (COS_W+2)'(cos_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_table) begin
         c_ff <= c_in;
      end
      if (cmd.multiply) begin
         prod_ff <= amp_ff * $signed({1'b0, c_ff});
      end
   end

   // Round half up, apply to the base and clamp to the position range.
   always_comb begin
      if (outer_ff) begin
         rounded    = prod_ff + (PROD_W'(1) <<< COS_W);
         swing_full = rounded >>> (COS_W + 1);
      end else begin
         rounded    = prod_ff + (PROD_W'(1) <<< (COS_W - 1));
         swing_full = rounded >>> COS_W;
      end
      swing    = swing_full[SUM_W-1:0];
      base_ext = SUM_W'(base_ff);
      sum_w    = add_ff ? base_ext + swing : base_ext - swing;
      if (sum_w > SUM_POS_MAX) begin
         target_in = {1'b0, {(POS_W-1){1'b1}}};
      end else if (sum_w < SUM_POS_MIN) begin
         target_in = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         target_in = sum_w[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         target_ff <= '0;
      end else if (cmd.sum) begin
         target_ff <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         rsp_target_ff <= target_ff;
         rsp_tvalid_ff <= hit_ff;
         rsp_left_ff   <= left_ff;
         rsp_done_ff   <= done_ff;
      end
   end

   assign sts.hit      = seg1 | seg2 | seg3;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_pos   = rsp_target_ff;
   assign rsp_target_valid = rsp_tvalid_ff;
   assign rsp_ticks_left   = rsp_left_ff;
   assign rsp_move_done    = rsp_done_ff;

endmodule

// ===== rtl/raised_cosine_oscillation_profile.sv =====
// Raised-cosine oscillation profile for one servo axis.
// The req channel takes one control tick per beat: req_first_tick restarts
// the move at tick one and req_actual_pos is the measured position. The rsp
// channel returns one beat per tick with the commanded position, a flag that
// the tick lies inside the move, the ticks left and a done flag. Both
// channels move a beat when valid is high and stall is low.
// The csr port writes amplitude, period_ticks and cycle_count by index; it
// is always ready. The user must write it only while no tick is in flight;
// the block itself does not enforce this. A tick inside the move runs two
// divisions on one shared restoring divider (tick within the period, then
// the phase index), a table read, a 32x19 multiply and a round/clamp step
// before the result is written; a tick outside the move goes straight to
// the write of its result, and no new tick is taken until that write.
// req_stall is high while a tick is being processed. The result waits in an
// output register, so a stall on rsp delays only the final write of the
// next tick. Reset clears the tick counter, base position and pending
// result and loads the register defaults; the cosine table is constant.
module raised_cosine_oscillation_profile import rcop_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_first_tick,
   input  logic signed [POS_W-1:0] req_actual_pos,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_target_pos,
   output logic                    rsp_target_valid,
   output logic [CNT_W-1:0]        rsp_ticks_left,
   output logic                    rsp_move_done,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   rcop_cmd_type cmd;
   rcop_sts_type sts;

   rcop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcop_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_first_tick   (req_first_tick),
      .req_actual_pos   (req_actual_pos),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target_pos   (rsp_target_pos),
      .rsp_target_valid (rsp_target_valid),
      .rsp_ticks_left   (rsp_ticks_left),
      .rsp_move_done    (rsp_move_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

// ===== rtl/rcop_check.sv =====
module rcop_check import rcop_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [POS_W-1:0] rsp_target_pos,
   input logic                    rsp_target_valid,
   input logic [CNT_W-1:0]        rsp_ticks_left,
   input logic                    rsp_move_done
);

   // Ticks are processed one at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input beat accepted while a tick was in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_pos)
                                 && $stable(rsp_ticks_left))
      else $error("stalled result beat changed");

   a_done_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_done == (rsp_ticks_left == '0)))
      else $error("done flag disagrees with ticks left");

   a_idle_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_target_valid |-> rsp_target_pos == '0)
      else $error("target outside the move is not zero");

endmodule

bind raised_cosine_oscillation_profile rcop_check u_rcop_check (.*);

// ===== test/tb.sv =====
module tb;
   import rcop_pkg::*;

   typedef longint unsigned u64_type;

   typedef struct {
      logic signed [POS_W-1:0] target;
      logic                    in_move;
      logic [CNT_W-1:0]        remaining;
      logic                    finished;
   } setpoint_type;

   // Indexes past the last register; writes there must leave every register alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_INDEX = 8'hFF;
   localparam logic [CNT_W-1:0]     TICK_CEILING  = 24'hFFFFFF;
   localparam int                   RANDOM_TICKS  = 1200;

   class profile_scoreboard;
      logic [COS_W-1:0] quarter_sine [COS_TABLE_DEPTH];
      int               amp;
      bit [PER_W-1:0]   period;
      bit [CYC_W-1:0]   cycles;
      bit [CNT_W-1:0]   tick;
      int               base;
      setpoint_type     pending_setpoints [$];
      int               mismatches;
      int               beats;

      function new();
         u64_type x, x2, term, r;
         longint acc;
         amp = 0;
         period = PERIOD_RESET;
         cycles = CYCLES_RESET;
         tick = '0;
         base = 0;
         mismatches = 0;
         beats = 0;
         // Quarter-wave sine from a Q30 Taylor series, rounded into Q0.16.
         for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            x = u64_type'(i) * HALF_PI_Q30 / COS_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            acc = longint'(x);
            for (int n = 1; n <= 8; n++) begin
               term = ((term * x2) >> 30) / u64_type'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) acc = acc - longint'(term);
               else acc = acc + longint'(term);
            end
            if (acc < 0) begin
               quarter_sine[i] = '0;
            end else begin
               r = (u64_type'(acc) + 8192) >> 14;
               quarter_sine[i] = (r > 65535) ? 16'hFFFF : r[COS_W-1:0];
            end
         end
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_AMPLITUDE:    amp = data;
            CSR_PERIOD_TICKS: period = data[PER_W-1:0];
            CSR_CYCLE_COUNT:  cycles = data[CYC_W-1:0];
            default: ;
         endcase
      endfunction

      function int cos_at(int unsigned idx);
         int unsigned q, r;
         int c0, s0;
         q = (idx / COS_TABLE_DEPTH) & 3;
         r = idx % COS_TABLE_DEPTH;
         c0 = (r == 0) ? 65536 : int'(quarter_sine[COS_TABLE_DEPTH - r]);
         s0 = int'(quarter_sine[r]);
         case (q)
            0: return c0;
            1: return -s0;
            2: return -c0;
            default: return s0;
         endcase
      endfunction

      function int swing_point(int unsigned j, int shift, bit add);
         u64_type full, idx;
         longint c, prod, swing, t;
         full = 4 * COS_TABLE_DEPTH;
         if (period == 0) return base;
         idx = ((u64_type'(j % period) * full * 2 + period) / (2 * u64_type'(period))) % full;
         c = 65536 - cos_at(int'(idx));
         prod = longint'(amp) * c;
         swing = (prod + (longint'(1) << (shift - 1))) >>> shift;
         t = add ? longint'(base) + swing : longint'(base) - swing;
         if (t > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
         if (t < -longint'(64'sd2147483648)) return 32'sh80000000;
         return int'(t);
      endfunction

      function void note_tick(logic first, logic signed [POS_W-1:0] pos);
         int unsigned T, H, total, k;
         setpoint_type e;
         if (first) tick = 1;
         else if (tick != TICK_CEILING) tick = tick + 1;
         k = tick;
         T = period;
         H = T / 2;
         total = cycles * T;
         e.target = '0;
         e.in_move = 1'b0;
         // Segments are tried in order; the first match wins.
         if (k >= 1 && k <= H) begin
            if (k == 1) base = pos;
            e.target = swing_point(k, 17, 1'b1);
            e.in_move = 1'b1;
         end else if (k > H && total >= H && k <= total - H) begin
            if (k == H + 1) base = pos;
            e.target = swing_point(k - H, 16, 1'b0);
            e.in_move = 1'b1;
         end else if (total >= H && k > total - H && k <= total) begin
            if (k == total - H + 1) base = pos;
            e.target = swing_point(k - (total - H), 17, 1'b0);
            e.in_move = 1'b1;
         end
         e.remaining = (k < total) ? 24'(total - k) : '0;
         e.finished = (k >= total);
         pending_setpoints.push_back(e);
      endfunction

      function void check_beat(setpoint_type got);
         setpoint_type want;
         beats++;
         if (pending_setpoints.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d arrived with nothing expected, target %h", beats, got.target);
            return;
         end
         want = pending_setpoints.pop_front();
         if (got.target !== want.target || got.in_move !== want.in_move ||
             got.remaining !== want.remaining || got.finished !== want.finished) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d: target %h/%h valid %b/%b left %0d/%0d done %b/%b (got/exp)",
                        beats, got.target, want.target, got.in_move, want.in_move,
                        got.remaining, want.remaining, got.finished, want.finished);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_first_tick = 1'b0;
   logic signed [POS_W-1:0] req_actual_pos = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_target_pos;
   logic                    rsp_target_valid;
   logic [CNT_W-1:0]        rsp_ticks_left;
   logic                    rsp_move_done;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   logic                    calm = 1'b0;
   int                      ticks_sent = 0;
   profile_scoreboard       sb;

   raised_cosine_oscillation_profile uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_tick(req_first_tick), .req_actual_pos(req_actual_pos),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_target_pos(rsp_target_pos), .rsp_target_valid(rsp_target_valid),
      .rsp_ticks_left(rsp_ticks_left), .rsp_move_done(rsp_move_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin : monitor
      setpoint_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.target = rsp_target_pos;
            got.in_move = rsp_target_valid;
            got.remaining = rsp_ticks_left;
            got.finished = rsp_move_done;
            sb.check_beat(got);
         end
         if (req_valid && !req_stall) sb.note_tick(req_first_tick, req_actual_pos);
         if (csr_valid && csr_ready) sb.apply_reg(csr_index, csr_data);
      end
   end

   function automatic logic [POS_W-1:0] pick_pos();
      case ($urandom_range(7))
         0: return 32'h7FFFFFFF - $urandom_range(0, 65535);
         1: return 32'h80000000 + $urandom_range(0, 65535);
         2: return 32'($urandom_range(0, 131072)) - 32'd65536;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_amplitude();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         default: return $urandom();
      endcase
   endfunction

   // Leaves req_valid high after the accepting edge so the next beat can follow at once.
   task automatic send_tick(input logic first, input logic [POS_W-1:0] pos);
      if (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3))
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_tick <= first;
      req_actual_pos <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_setpoints.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_profile(input logic [31:0] amp, input logic [31:0] per,
                                  input logic [31:0] cyc, input bit stray);
      drain();
      repeat (4) @(posedge clock);
      csr_write(CSR_AMPLITUDE, amp);
      csr_write(CSR_PERIOD_TICKS, per);
      csr_write(CSR_CYCLE_COUNT, cyc);
      if (stray) begin
         csr_write(CSR_UNMAPPED, $urandom());
         csr_write(CSR_TOP_INDEX, $urandom());
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      #18000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int unsigned per, cyc, total, len, moves;
      int phase;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults; a tick without first_tick after reset counts as tick one.
      send_tick(1'b0, 32'h7FFFFFFF);
      send_tick(1'b0, 32'h80000000);

      // Short move through all three segments, with bits above each register
      // width set and stray writes past the last register.
      program_profile(32'h80000000, 32'hABCD0004, 32'hFFFFFF02, 1'b1);
      send_tick(1'b1, 32'h7FFF0000);
      for (int i = 0; i < 8; i++) begin
         if (i == 3) drain();
         send_tick(1'b0, (i < 4) ? 32'h7FFFFF00 : pick_pos());
      end

      // Period one: no first segment and the target holds the base.
      program_profile(32'h7FFFFFFF, 32'd1, 32'd3, 1'b0);
      send_tick(1'b1, 32'h80000001);
      repeat (3) send_tick(1'b0, pick_pos());

      // Period zero: nothing is inside the move. Zero periods: only tick one is.
      program_profile(32'h12345678, 32'd0, 32'd5, 1'b0);
      send_tick(1'b1, pick_pos());
      send_tick(1'b0, pick_pos());
      program_profile(32'hFFFF0000, 32'd3, 32'd0, 1'b0);
      send_tick(1'b1, pick_pos());

      // Longest move the registers allow; only its first ticks.
      program_profile(32'h7FFFFFFF, 32'd65535, 32'd255, 1'b0);
      send_tick(1'b1, 32'h80000000);
      send_tick(1'b0, pick_pos());

      phase = 0;
      ticks_sent = 0;
      while (ticks_sent < RANDOM_TICKS) begin
         phase++;
         case ($urandom_range(15))
            0: per = 65535;
            1, 2: per = $urandom_range(13, 400);
            default: per = $urandom_range(2, 12);
         endcase
         case ($urandom_range(7))
            0: cyc = 255;
            1: cyc = $urandom_range(5, 254);
            default: cyc = $urandom_range(1, 4);
         endcase
         program_profile(pick_amplitude(), {16'($urandom()), per[15:0]},
                         {24'($urandom()), cyc[7:0]}, $urandom_range(9) == 0);
         calm = (phase == 4);
         total = per * cyc;
         // The stretch without idling runs long enough to keep both sides busy.
         moves = calm ? 4 : $urandom_range(1, 4);
         for (int m = 0; m < moves; m++) begin
            len = total + $urandom_range(0, 3);
            if (len > 60) len = $urandom_range(20, 60);
            if (calm && len < 30) len = 30;
            send_tick(1'b1, pick_pos());
            for (int i = 1; i < len; i++) begin
               if ($urandom_range(39) == 0) drain();
               // Now and then a restart lands in the middle of a move.
               send_tick($urandom_range(29) == 0, pick_pos());
            end
         end
         calm = 1'b0;
      end

      drain();
      repeat (80) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_setpoints.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (sb.pending_setpoints.size() != 0)
            $display("%0d expected beats never arrived", sb.pending_setpoints.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rcop_pkg.sv
rtl/rcop_div.sv
rtl/rcop_ctrl.sv
rtl/rcop_dpath.sv
rtl/raised_cosine_oscillation_profile.sv
rtl/rcop_check.sv
test/tb.sv
